/* rtl/pva_pkg.sv */
// Shared types and constants of the polyphonic voice allocator.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pva_pkg;

  // Fixed widths of the item fields and of the configuration register.
  localparam int KEY_W    = 7;
  localparam int VOICE_W  = 4;
  localparam int POS_W    = 63;
  localparam int MASK_W   = 16;
  localparam int ACTIVE_W = 5;
  localparam int CFG_W    = 8;

  // Number of keys scanned by release-all after reset.
  localparam logic [CFG_W-1:0] KEY_COUNT_RESET = 8'd128;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TRIGGER     = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_VOICE_END   = 2'd3
  } pva_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } pva_state_t;

  // Write controls of a table: set marks an entry in use and writes its data,
  // clr marks it free.
  typedef struct packed {
    logic set;
    logic clr;
  } pva_wr_t;

endpackage

`default_nettype wire

/* rtl/pva_voice_table.sv */
// Per-voice state: busy flags in flip-flops, owner key and start position in memories.
// Depends on pva_pkg for field widths and the write control struct.
`default_nettype none

module pva_voice_table #(
  parameter  int NUM_VOICES = 16,
  localparam int VIW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [VIW-1:0]                 rd_addr,
  output logic                          rd_busy,
  output logic [pva_pkg::KEY_W-1:0]     rd_owner,
  output logic [pva_pkg::POS_W-1:0]     rd_start,
  output logic [NUM_VOICES-1:0]         busy_vec,
  input  pva_pkg::pva_wr_t              wr_ctl,
  input  wire [VIW-1:0]                 wr_addr,
  input  wire [pva_pkg::KEY_W-1:0]      wr_key,
  input  wire [pva_pkg::POS_W-1:0]      wr_pos
);

  logic [NUM_VOICES-1:0]     busy;
  logic [pva_pkg::KEY_W-1:0] owner_mem [NUM_VOICES];
  logic [pva_pkg::POS_W-1:0] start_mem [NUM_VOICES];

  // Busy flags are cleared by reset; a set wins over a clr, though
  // set and clr never come together.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (wr_ctl.set) begin
      busy[wr_addr] <= 1'b1;
    end else if (wr_ctl.clr) begin
      busy[wr_addr] <= 1'b0;
    end
  end

  // Owner and start position are only read while the voice is busy.
  always_ff @(posedge clk) begin
    if (wr_ctl.set) begin
      owner_mem[wr_addr] <= wr_key;
      start_mem[wr_addr] <= wr_pos;
    end
  end

  // Registered read port used by the scan.
  always_ff @(posedge clk) begin
    rd_busy  <= busy[rd_addr];
    rd_owner <= owner_mem[rd_addr];
    rd_start <= start_mem[rd_addr];
  end

  assign busy_vec = busy;

endmodule

`default_nettype wire

/* rtl/pva_key_map.sv */
// Key map: a valid flag per key in flip-flops and the latest voice of each key in a memory.
// Depends on pva_pkg for the write control struct.
`default_nettype none

module pva_key_map #(
  parameter  int NUM_VOICES = 16,
  parameter  int NUM_KEYS   = 128,
  localparam int VIW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int KIW        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire [KIW-1:0]       rd_addr,
  output logic                rd_has,
  output logic [VIW-1:0]      rd_latest,
  input  pva_pkg::pva_wr_t    wr_ctl,
  input  wire [KIW-1:0]       wr_addr,
  input  wire [VIW-1:0]       wr_voice
);

  logic [NUM_KEYS-1:0] has_voice;
  logic [VIW-1:0]      latest_mem [NUM_KEYS];

  // Valid flags, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_voice <= '0;
    end else if (wr_ctl.set) begin
      has_voice[wr_addr] <= 1'b1;
    end else if (wr_ctl.clr) begin
      has_voice[wr_addr] <= 1'b0;
    end
  end

  // Latest voice of a key; an entry is read only while its flag is set.
  always_ff @(posedge clk) begin
    if (wr_ctl.set) begin
      latest_mem[wr_addr] <= wr_voice;
    end
  end

  // Registered read port used by the release-all scan.
  always_ff @(posedge clk) begin
    rd_has    <= has_voice[rd_addr];
    rd_latest <= latest_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/pva_seq.sv */
// Sequencer of the allocator: scans voices or keys one entry a cycle through a
// shared compare unit, then commits the table writes and registers the result item.
// Depends on pva_pkg; drives pva_voice_table and pva_key_map.
`default_nettype none

module pva_seq #(
  parameter  int NUM_VOICES = 16,
  parameter  int NUM_KEYS   = 128,
  localparam int VIW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int KIW        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
  localparam int SCAN_MAX   = (NUM_VOICES > NUM_KEYS) ? NUM_VOICES : NUM_KEYS,
  localparam int NW         = $clog2(SCAN_MAX + 1)
) (
  input  wire                            clk,
  input  wire                            rst,
  // Command side
  input  wire                            start,
  output logic                           busy,
  input  wire [1:0]                      opcode,
  input  wire [pva_pkg::KEY_W-1:0]       key,
  input  wire [pva_pkg::VOICE_W-1:0]     voice,
  input  wire [pva_pkg::POS_W-1:0]       position,
  input  wire [NW-1:0]                   key_lim,
  // Result side
  output logic                           done,
  output logic [pva_pkg::VOICE_W-1:0]    voice_index,
  output logic                           stolen,
  output logic [pva_pkg::MASK_W-1:0]     release_mask,
  output logic [pva_pkg::ACTIVE_W-1:0]   active_voices,
  // Voice table
  output logic [VIW-1:0]                 vt_rd_addr,
  input  wire                            vt_rd_busy,
  input  wire [pva_pkg::KEY_W-1:0]       vt_rd_owner,
  input  wire [pva_pkg::POS_W-1:0]       vt_rd_start,
  input  wire [NUM_VOICES-1:0]           vt_busy_vec,
  output pva_pkg::pva_wr_t               vt_wr_ctl,
  output logic [VIW-1:0]                 vt_wr_addr,
  output logic [pva_pkg::KEY_W-1:0]      vt_wr_key,
  output logic [pva_pkg::POS_W-1:0]      vt_wr_pos,
  // Key map
  output logic [KIW-1:0]                 km_rd_addr,
  input  wire                            km_rd_has,
  input  wire [VIW-1:0]                  km_rd_latest,
  output pva_pkg::pva_wr_t               km_wr_ctl,
  output logic [KIW-1:0]                 km_wr_addr,
  output logic [VIW-1:0]                 km_wr_voice
);

  localparam int CW       = $clog2(NUM_VOICES + 1);

  pva_pkg::pva_state_t state, state_next;

  // Item registers.
  pva_pkg::pva_op_t              op_q;
  logic [pva_pkg::KEY_W-1:0]     key_q;
  logic [pva_pkg::VOICE_W-1:0]   voice_q;
  logic [pva_pkg::POS_W-1:0]     pos_q;

  // Scan control.
  logic [NW-1:0]  idx;
  logic [NW-1:0]  idx_d;
  logic [NW-1:0]  scan_len;
  logic [NW-1:0]  scan_len_in;
  logic           rd_vld;

  // Scan accumulators.
  logic                      found;
  logic [VIW-1:0]            free_vic;
  logic [VIW-1:0]            old_vic;
  logic [pva_pkg::POS_W-1:0] oldest;
  logic [NUM_VOICES-1:0]     mask;

  logic [CW-1:0] count, count_next;

  // Shared compare unit and commit decisions.
  logic                  start_lt;
  logic                  owner_eq;
  logic [VIW-1:0]        vic;
  logic [VIW-1:0]        end_voice;
  logic                  voice_ok;
  logic                  key_ok;
  logic                  end_ok;
  logic [NUM_VOICES-1:0] others;
  logic                  accept;
  pva_pkg::pva_op_t      op_in;

  assign accept      = start && (state == pva_pkg::ST_IDLE);
  assign op_in       = pva_pkg::pva_op_t'(opcode);
  assign scan_len_in = (op_in == pva_pkg::OP_RELEASE_ALL) ? key_lim : NW'(NUM_VOICES);

  // The compare unit sees one scanned entry per cycle.
  always_comb begin
    start_lt = vt_rd_start < oldest;
    owner_eq = vt_rd_owner == key_q;
  end

  // Commit decisions made once the scan has finished.
  always_comb begin
    vic       = found ? free_vic : old_vic;
    end_voice = VIW'(voice_q);
    voice_ok  = int'(voice_q) < NUM_VOICES;
    key_ok    = int'(key_q) < NUM_KEYS;
    end_ok    = voice_ok && vt_busy_vec[end_voice];
    others    = mask & ~(NUM_VOICES'(1) << end_voice);
  end

  // Voice count after the item.
  always_comb begin
    count_next = count;
    case (op_q)
      pva_pkg::OP_TRIGGER: begin
        if (found) begin
          count_next = count + CW'(1);
        end
      end
      pva_pkg::OP_VOICE_END: begin
        if (end_ok && (count != '0)) begin
          count_next = count - CW'(1);
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pva_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (scan_len_in == '0) ? pva_pkg::ST_FINISH : pva_pkg::ST_SCAN;
        end
      end
      pva_pkg::ST_SCAN: begin
        if (idx == scan_len - NW'(1)) begin
          state_next = pva_pkg::ST_LAST;
        end
      end
      pva_pkg::ST_LAST: begin
        state_next = pva_pkg::ST_FINISH;
      end
      pva_pkg::ST_FINISH: begin
        state_next = pva_pkg::ST_IDLE;
      end
      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

  // Table addresses and write strobes.
  always_comb begin
    vt_rd_addr  = idx[VIW-1:0];
    km_rd_addr  = idx[KIW-1:0];
    vt_wr_ctl   = '0;
    vt_wr_addr  = vic;
    vt_wr_key   = key_q;
    vt_wr_pos   = pos_q;
    km_wr_ctl   = '0;
    km_wr_addr  = KIW'(key_q);
    km_wr_voice = vic;
    if (state == pva_pkg::ST_FINISH) begin
      case (op_q)
        pva_pkg::OP_TRIGGER: begin
          vt_wr_ctl.set = 1'b1;
          km_wr_ctl.set = key_ok;
        end
        pva_pkg::OP_VOICE_END: begin
          vt_wr_addr    = end_voice;
          vt_wr_ctl.clr = end_ok;
          km_wr_ctl.clr = end_ok && key_ok && (others == '0);
        end
        default: begin
          vt_wr_ctl = '0;
          km_wr_ctl = '0;
        end
      endcase
    end
  end

  assign busy = (state != pva_pkg::ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pva_pkg::ST_IDLE;
      rd_vld <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == pva_pkg::ST_SCAN);
      done   <= (state == pva_pkg::ST_FINISH);
      if (state == pva_pkg::ST_FINISH) begin
        count <= count_next;
      end
    end
  end

  // Item capture and scan counter.
  always_ff @(posedge clk) begin
    idx_d <= idx;
    if (accept) begin
      op_q     <= op_in;
      key_q    <= key;
      voice_q  <= voice;
      pos_q    <= position;
      scan_len <= scan_len_in;
      idx      <= '0;
    end else if (state == pva_pkg::ST_SCAN) begin
      idx <= idx + NW'(1);
    end
  end

  // Accumulate one scanned entry per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      found <= 1'b0;
      mask  <= '0;
    end else if (rd_vld) begin
      case (op_q)
        pva_pkg::OP_TRIGGER: begin
          if (!found && !vt_rd_busy) begin
            found    <= 1'b1;
            free_vic <= idx_d[VIW-1:0];
          end
          if ((idx_d == '0) || start_lt) begin
            oldest  <= vt_rd_start;
            old_vic <= idx_d[VIW-1:0];
          end
        end
        pva_pkg::OP_RELEASE_ALL: begin
          if (km_rd_has) begin
            mask[km_rd_latest] <= 1'b1;
          end
        end
        default: begin
          // Release and voice-ended both look for busy voices of the key.
          if (vt_rd_busy && owner_eq) begin
            mask[idx_d[VIW-1:0]] <= 1'b1;
          end
        end
      endcase
    end
  end

  // Result item, registered at the commit and flagged by done for one cycle.
  always_ff @(posedge clk) begin
    if (state == pva_pkg::ST_FINISH) begin
      voice_index   <= (op_q == pva_pkg::OP_TRIGGER) ? pva_pkg::VOICE_W'(vic) : '0;
      stolen        <= (op_q == pva_pkg::OP_TRIGGER) && !found;
      release_mask  <= ((op_q == pva_pkg::OP_RELEASE) || (op_q == pva_pkg::OP_RELEASE_ALL))
                       ? pva_pkg::MASK_W'(mask) : '0;
      active_voices <= pva_pkg::ACTIVE_W'(count_next);
    end
  end

endmodule

`default_nettype wire

/* rtl/poly_voice_allocator.sv */
// Top level of the polyphonic voice allocator: key count register and wiring.
// Depends on pva_pkg, pva_voice_table, pva_key_map and pva_seq.
//
//   Channel   Handshake               Signals
//   command   start & !busy accepts   opcode, key, voice, position
//   result    done, one cycle         voice_index, stolen, release_mask, active_voices
//   config    cfg_we                  cfg_data (key_count)
//
// Trigger, release and voice-ended items scan every voice once, one voice per
// cycle through the shared compare unit. Release-all scans min(key_count,
// NUM_KEYS) keys of the key map memory instead and skips the scan when that
// count is zero; done follows each scan through the last and finish states.
// Reset is synchronous and clears all voices and the key map at once.
// The result is flagged by done for one cycle only; the receiver cannot stall it.
`default_nettype none

module poly_voice_allocator #(
  parameter int NUM_VOICES = 16,
  parameter int NUM_KEYS   = 128
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire [1:0]                      opcode,
  input  wire [pva_pkg::KEY_W-1:0]       key,
  input  wire [pva_pkg::VOICE_W-1:0]     voice,
  input  wire [pva_pkg::POS_W-1:0]       position,
  output logic                           done,
  output logic [pva_pkg::VOICE_W-1:0]    voice_index,
  output logic                           stolen,
  output logic [pva_pkg::MASK_W-1:0]     release_mask,
  output logic [pva_pkg::ACTIVE_W-1:0]   active_voices,
  input  wire                            cfg_we,
  input  wire [pva_pkg::CFG_W-1:0]       cfg_data
);

  localparam int VIW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int KIW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int SCAN_MAX = (NUM_VOICES > NUM_KEYS) ? NUM_VOICES : NUM_KEYS;
  localparam int NW       = $clog2(SCAN_MAX + 1);

  logic [pva_pkg::CFG_W-1:0] key_count;
  logic [NW-1:0]             key_lim;

  logic                      vt_rd_busy;
  logic [VIW-1:0]            vt_rd_addr;
  logic [pva_pkg::KEY_W-1:0] vt_rd_owner;
  logic [pva_pkg::POS_W-1:0] vt_rd_start;
  logic [NUM_VOICES-1:0]     vt_busy_vec;
  pva_pkg::pva_wr_t          vt_wr_ctl;
  logic [VIW-1:0]            vt_wr_addr;
  logic [pva_pkg::KEY_W-1:0] vt_wr_key;
  logic [pva_pkg::POS_W-1:0] vt_wr_pos;

  logic [KIW-1:0]            km_rd_addr;
  logic                      km_rd_has;
  logic [VIW-1:0]            km_rd_latest;
  pva_pkg::pva_wr_t          km_wr_ctl;
  logic [KIW-1:0]            km_wr_addr;
  logic [VIW-1:0]            km_wr_voice;

  // Key count register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= pva_pkg::KEY_COUNT_RESET;
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // The release-all scan never goes past the last key of the map.
  always_comb begin
    if (int'(key_count) < NUM_KEYS) begin
      key_lim = NW'(key_count);
    end else begin
      key_lim = NW'(NUM_KEYS);
    end
  end

  pva_voice_table #(
    .NUM_VOICES (NUM_VOICES)
  ) u_voice_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (vt_rd_addr),
    .rd_busy  (vt_rd_busy),
    .rd_owner (vt_rd_owner),
    .rd_start (vt_rd_start),
    .busy_vec (vt_busy_vec),
    .wr_ctl   (vt_wr_ctl),
    .wr_addr  (vt_wr_addr),
    .wr_key   (vt_wr_key),
    .wr_pos   (vt_wr_pos)
  );

  pva_key_map #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_KEYS   (NUM_KEYS)
  ) u_key_map (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (km_rd_addr),
    .rd_has    (km_rd_has),
    .rd_latest (km_rd_latest),
    .wr_ctl    (km_wr_ctl),
    .wr_addr   (km_wr_addr),
    .wr_voice  (km_wr_voice)
  );

  pva_seq #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_KEYS   (NUM_KEYS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .key           (key),
    .voice         (voice),
    .position      (position),
    .key_lim       (key_lim),
    .done          (done),
    .voice_index   (voice_index),
    .stolen        (stolen),
    .release_mask  (release_mask),
    .active_voices (active_voices),
    .vt_rd_addr    (vt_rd_addr),
    .vt_rd_busy    (vt_rd_busy),
    .vt_rd_owner   (vt_rd_owner),
    .vt_rd_start   (vt_rd_start),
    .vt_busy_vec   (vt_busy_vec),
    .vt_wr_ctl     (vt_wr_ctl),
    .vt_wr_addr    (vt_wr_addr),
    .vt_wr_key     (vt_wr_key),
    .vt_wr_pos     (vt_wr_pos),
    .km_rd_addr    (km_rd_addr),
    .km_rd_has     (km_rd_has),
    .km_rd_latest  (km_rd_latest),
    .km_wr_ctl     (km_wr_ctl),
    .km_wr_addr    (km_wr_addr),
    .km_wr_voice   (km_wr_voice)
  );

endmodule

`default_nettype wire
